// File: hw/rtl/tkrt_pkg.sv
// ----------------------------------------------------------------------------
// tkrt_pkg - shared types and constants for the ranked table
// field widths, request codes and the command broadcast to every cell
// ----------------------------------------------------------------------------
package tkrt_pkg;

	localparam int DEPTH_DEFAULT = 10;

	localparam int LEVEL_W = 16;
	localparam int SCORE_W = 32;
	localparam int INDEX_W = 4;
	localparam int RANK_W  = 4;
	localparam int COUNT_W = 4;

	// request kinds carried on s_axis_tuser
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	// input item: level, score, index from bit 0 up, padded to 56 bits
	localparam int IN_DATA_W  = 56;
	// result item: accepted, rank, entry_valid, entry_level, entry_score, count
	localparam int OUT_DATA_W = 64;

	// insert command seen by every cell in the same cycle
	typedef struct packed {
		logic               ins;
		logic [SCORE_W-1:0] score;
		logic [LEVEL_W-1:0] level;
	} cmd_t;

endpackage

// File: hw/rtl/tkrt_cell.sv
// ----------------------------------------------------------------------------
// tkrt_cell - one position of the ranked table
// compares the new entry with its own, takes it or the upper neighbor's entry
// ----------------------------------------------------------------------------
module tkrt_cell (
	input  logic                          clk,
	input  tkrt_pkg::cmd_t                cmd,
	input  logic                          live,      // this position holds an entry
	input  logic                          below_in,  // new entry ranks below all cells above
	input  logic [tkrt_pkg::SCORE_W-1:0]  up_score,
	input  logic [tkrt_pkg::LEVEL_W-1:0]  up_level,
	output logic                          below_out,
	output logic                          here,      // this is the insertion point
	output logic [tkrt_pkg::SCORE_W-1:0]  score,
	output logic [tkrt_pkg::LEVEL_W-1:0]  level
);

	logic [tkrt_pkg::SCORE_W-1:0] score_q;
	logic [tkrt_pkg::LEVEL_W-1:0] level_q;
	logic                         here_below;

	always_comb begin
		here_below = live && ((cmd.score < score_q) ||
			((cmd.score == score_q) && (cmd.level < level_q)));
		below_out  = below_in && here_below;
		here       = below_in && !here_below;
	end

	// insertion point takes the new entry, everything after it shifts down
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (here) begin
				score_q <= cmd.score;
				level_q <= cmd.level;
			end else if (!below_in) begin
				score_q <= up_score;
				level_q <= up_level;
			end
		end
	end

	assign score = score_q;
	assign level = level_q;

endmodule

// File: hw/rtl/top_k_ranked_table.sv
// ----------------------------------------------------------------------------
// top_k_ranked_table - ranked table of the best DEPTH (score, level) entries
// row of compare-and-shift cells, one result item per request item
// ----------------------------------------------------------------------------
// result: registered, on the master side in the cycle after the item is accepted
// throughput: one item per cycle, set by the single compare-and-shift step
//   that all cells take in parallel; the input stalls while a result waits
//   on m_axis_tready
// reset: arst_n clears the entry count and the result valid; cell contents
//   are undefined until written and never read beyond the count
module top_k_ranked_table #(
	parameter int DEPTH = tkrt_pkg::DEPTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// level[15:0], score[47:16], index[51:48], zero pad
	input  logic [tkrt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// req_type[0]
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// accepted[0], rank[4:1], entry_valid[5], entry_level[21:6],
	// entry_score[53:22], count[57:54], zero pad
	output logic [tkrt_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int RANK_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RES_W  = 1 + tkrt_pkg::RANK_W + 1 + tkrt_pkg::LEVEL_W +
		tkrt_pkg::SCORE_W + tkrt_pkg::COUNT_W;

	// input field split
	logic [tkrt_pkg::LEVEL_W-1:0] in_level;
	logic [tkrt_pkg::SCORE_W-1:0] in_score;
	logic [tkrt_pkg::INDEX_W-1:0] in_index;
	logic                         take;

	assign in_level = s_axis_tdata[15:0];
	assign in_score = s_axis_tdata[47:16];
	assign in_index = s_axis_tdata[51:48];

	// result register: a new item is taken while it is empty or its old result leaves
	logic                  out_valid_q;
	logic [RES_W-1:0]      out_data_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign take          = s_axis_tvalid && s_axis_tready;

	logic [CNT_W-1:0] count_q;

	// command to the cell row
	tkrt_pkg::cmd_t cmd;
	always_comb begin
		cmd.ins   = take && (s_axis_tuser == tkrt_pkg::REQ_INSERT);
		cmd.score = in_score;
		cmd.level = in_level;
	end

	// cell row with the "ranks below everything above" chain
	logic [DEPTH:0]               below_chain;
	logic [DEPTH-1:0]             cell_here;
	logic [DEPTH-1:0]             cell_live;
	logic [tkrt_pkg::SCORE_W-1:0] cell_score [DEPTH];
	logic [tkrt_pkg::LEVEL_W-1:0] cell_level [DEPTH];

	assign below_chain[0] = 1'b1;

	for (genvar p = 0; p < DEPTH; p++) begin : g_cell
		logic [tkrt_pkg::SCORE_W-1:0] up_score;
		logic [tkrt_pkg::LEVEL_W-1:0] up_level;

		// first cell has no upper neighbor; it never shifts
		if (p == 0) begin : g_top
			assign up_score = in_score;
			assign up_level = in_level;
		end else begin : g_mid
			assign up_score = cell_score[p-1];
			assign up_level = cell_level[p-1];
		end

		assign cell_live[p] = (32'(count_q) > p);

		tkrt_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.live      (cell_live[p]),
			.below_in  (below_chain[p]),
			.up_score  (up_score),
			.up_level  (up_level),
			.below_out (below_chain[p+1]),
			.here      (cell_here[p]),
			.score     (cell_score[p]),
			.level     (cell_level[p])
		);
	end

	// rank of the insertion point and read select, one-hot over the cells
	logic [RANK_W-1:0]            ins_rank;
	logic                         rd_valid;
	logic [tkrt_pkg::SCORE_W-1:0] rd_score;
	logic [tkrt_pkg::LEVEL_W-1:0] rd_level;
	logic                         ins_kept;
	logic [CNT_W-1:0]             count_nxt;

	always_comb begin
		ins_rank = '0;
		rd_valid = 1'b0;
		rd_score = '0;
		rd_level = '0;
		for (int p = 0; p < DEPTH; p++) begin
			if (cell_here[p])
				ins_rank = ins_rank | RANK_W'(p);
			if ((32'(in_index) == p) && cell_live[p]) begin
				rd_valid = 1'b1;
				rd_score = rd_score | cell_score[p];
				rd_level = rd_level | cell_level[p];
			end
		end
	end

	// dropped only when the table is full and the entry ranks below all
	assign ins_kept = !below_chain[DEPTH];

	always_comb begin
		count_nxt = count_q;
		if (cmd.ins && ins_kept && (32'(count_q) < DEPTH))
			count_nxt = count_q + CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (take)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// result payload, unused fields of each request kind forced to zero
	always_ff @(posedge clk) begin
		if (take) begin
			if (s_axis_tuser == tkrt_pkg::REQ_INSERT) begin
				out_data_q <= {tkrt_pkg::COUNT_W'(count_nxt),
					tkrt_pkg::SCORE_W'(0), tkrt_pkg::LEVEL_W'(0), 1'b0,
					ins_kept ? tkrt_pkg::RANK_W'(ins_rank) : tkrt_pkg::RANK_W'(0),
					ins_kept};
			end else begin
				out_data_q <= {tkrt_pkg::COUNT_W'(count_q),
					rd_score, rd_level, rd_valid,
					tkrt_pkg::RANK_W'(0), 1'b0};
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = tkrt_pkg::OUT_DATA_W'(out_data_q);

endmodule

// File: tb/sv/top_k_ranked_table_tb.sv
// ----------------------------------------------------------------------------
// top_k_ranked_table_tb - self-checking bench for the ranked table
// drives insert and read items on the slave stream, predicts every result
// with its own copy of the table and checks each result item field by field
// ----------------------------------------------------------------------------
module top_k_ranked_table_tb;

	localparam int DEPTH = tkrt_pkg::DEPTH_DEFAULT;
	// generous watchdog, far beyond the slowest legal run
	localparam int WATCHDOG = 4_000_000;

	// one result item as the bench expects it
	typedef struct packed {
		logic                         accepted;
		logic [tkrt_pkg::RANK_W-1:0]  rank;
		logic                         entry_valid;
		logic [tkrt_pkg::LEVEL_W-1:0] entry_level;
		logic [tkrt_pkg::SCORE_W-1:0] entry_score;
		logic [tkrt_pkg::COUNT_W-1:0] count;
	} table_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	// level[15:0], score[47:16], index[51:48], zero pad
	logic [tkrt_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	// req_type[0]
	logic                            s_axis_tuser = tkrt_pkg::REQ_INSERT;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	// accepted[0], rank[4:1], entry_valid[5], entry_level[21:6],
	// entry_score[53:22], count[57:54], zero pad
	logic [tkrt_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	// bench copy of the table contents
	logic [tkrt_pkg::SCORE_W-1:0]    tbl_score [DEPTH];
	logic [tkrt_pkg::LEVEL_W-1:0]    tbl_level [DEPTH];
	int                              tbl_fill = 0;

	table_result_t                   pending_results [$];
	int                              fail_count = 0;
	int                              burst_left = 0;

	top_k_ranked_table #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// apply one request to the bench table and return the result it causes
	function automatic table_result_t rank_request(logic req,
			logic [tkrt_pkg::LEVEL_W-1:0] lvl, logic [tkrt_pkg::SCORE_W-1:0] scr,
			logic [tkrt_pkg::INDEX_W-1:0] idx);
		table_result_t r;
		int pos;
		int p;
		r = '0;
		if (req == tkrt_pkg::REQ_INSERT) begin
			// walk past every stored entry that outranks the new one
			pos = 0;
			while (pos < tbl_fill && (scr < tbl_score[pos] ||
					(scr == tbl_score[pos] && lvl < tbl_level[pos])))
				pos++;
			if (pos < DEPTH) begin
				// shift the lower part down, the last entry falls off when full
				for (p = (tbl_fill < DEPTH) ? tbl_fill : DEPTH - 1; p > pos; p--) begin
					tbl_score[p] = tbl_score[p-1];
					tbl_level[p] = tbl_level[p-1];
				end
				tbl_score[pos] = scr;
				tbl_level[pos] = lvl;
				if (tbl_fill < DEPTH)
					tbl_fill++;
				r.accepted = 1'b1;
				r.rank     = tkrt_pkg::RANK_W'(pos);
			end
		end else if (int'(idx) < tbl_fill) begin
			r.entry_valid = 1'b1;
			r.entry_level = tbl_level[idx];
			r.entry_score = tbl_score[idx];
		end
		r.count = tkrt_pkg::COUNT_W'(tbl_fill);
		return r;
	endfunction

	// send one item; called at a rising edge, returns at the edge that took it
	task automatic send_item(logic req, logic [tkrt_pkg::LEVEL_W-1:0] lvl,
			logic [tkrt_pkg::SCORE_W-1:0] scr, logic [tkrt_pkg::INDEX_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {4'b0, idx, scr, lvl};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_results.push_back(rank_request(req, lvl, scr, idx));
	endtask

	// stop sending and hold off until every expected result has come
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic test_empty_reads();
		send_item(tkrt_pkg::REQ_READ, 16'h0, 32'h0, 4'd0);
		send_item(tkrt_pkg::REQ_READ, 16'hffff, 32'hffff_ffff, 4'd15);
		wait_drained();
	endtask

	// extremes of both keys, exact ties and a read past a partial count
	task automatic test_fill_and_order();
		send_item(tkrt_pkg::REQ_INSERT, 16'h0000, 32'h0000_0000, 4'd0);
		send_item(tkrt_pkg::REQ_INSERT, 16'hffff, 32'hffff_ffff, 4'd15);
		send_item(tkrt_pkg::REQ_INSERT, 16'h0000, 32'hffff_ffff, 4'd0);
		send_item(tkrt_pkg::REQ_INSERT, 16'hffff, 32'hffff_ffff, 4'd0);
		send_item(tkrt_pkg::REQ_INSERT, 16'hffff, 32'h0000_0000, 4'd0);
		send_item(tkrt_pkg::REQ_READ, 16'h0, 32'h0, 4'd5);
		send_item(tkrt_pkg::REQ_INSERT, 16'h8000, 32'h8000_0000, 4'd0);
		send_item(tkrt_pkg::REQ_INSERT, 16'h1234, 32'h0000_1000, 4'd0);
		send_item(tkrt_pkg::REQ_INSERT, 16'h7fff, 32'h8000_0000, 4'd0);
		send_item(tkrt_pkg::REQ_INSERT, 16'haaaa, 32'h5555_5555, 4'd0);
		send_item(tkrt_pkg::REQ_INSERT, 16'h5555, 32'haaaa_aaaa, 4'd0);
		wait_drained();
	endtask

	// full table: bottom entry pushed out, entry below all dropped, new best
	task automatic test_full_table();
		send_item(tkrt_pkg::REQ_INSERT, 16'h0005, 32'h0000_0005, 4'd0);
		send_item(tkrt_pkg::REQ_INSERT, 16'h0000, 32'h0000_0000, 4'd0);
		send_item(tkrt_pkg::REQ_INSERT, 16'hffff, 32'hffff_ffff, 4'd0);
		send_item(tkrt_pkg::REQ_READ, 16'h0, 32'h0, 4'd0);
		send_item(tkrt_pkg::REQ_READ, 16'h0, 32'h0, 4'd9);
		send_item(tkrt_pkg::REQ_READ, 16'h0, 32'h0, 4'd10);
		send_item(tkrt_pkg::REQ_READ, 16'h0, 32'h0, 4'd15);
		wait_drained();
	endtask

	// mostly inserts close to stored entries so that every rank gets hit
	task automatic test_random_traffic(int n_items);
		logic [tkrt_pkg::LEVEL_W-1:0] lvl;
		logic [tkrt_pkg::SCORE_W-1:0] scr;
		logic [tkrt_pkg::INDEX_W-1:0] idx;
		int p;
		for (int i = 0; i < n_items; i++) begin
			lvl = tkrt_pkg::LEVEL_W'($urandom);
			scr = $urandom;
			idx = tkrt_pkg::INDEX_W'($urandom_range(0, 15));
			if ($urandom_range(0, 9) < 3) begin
				send_item(tkrt_pkg::REQ_READ, lvl, scr, idx);
			end else begin
				case ($urandom_range(0, 9))
					0: ;
					1: begin
						scr = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
						lvl = $urandom_range(0, 1) ? 16'hffff : 16'h0;
					end
					default: begin
						if (tbl_fill > 0) begin
							p = $urandom_range(0, tbl_fill - 1);
							scr = tbl_score[p] +
								tkrt_pkg::SCORE_W'($urandom_range(0, 2)) - 1;
							case ($urandom_range(0, 3))
								0: lvl = tbl_level[p];
								1: lvl = tbl_level[p] + 1'b1;
								2: lvl = tbl_level[p] - 1'b1;
								default: ;
							endcase
						end
					end
				endcase
				send_item(tkrt_pkg::REQ_INSERT, lvl, scr, idx);
			end
			// now and then let the pipe run dry
			if ($urandom_range(0, 149) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	// receiver stalls on its own pattern, in one of four modes picked at random
	int unsigned rx_cycle = 0;
	int unsigned rx_mode  = 0;
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 64 == 0)
			rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 1);
			2: m_axis_tready <= (rx_cycle % 3 != 0);
			default: m_axis_tready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	// four-state compare so that unknown bits count as a mismatch
	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// every result item is matched against the oldest expectation
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result item with no expectation, actual %0h", $time,
					m_axis_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("accepted", 64'(want.accepted), 64'(m_axis_tdata[0]));
				check_field("rank", 64'(want.rank), 64'(m_axis_tdata[4:1]));
				check_field("entry_valid", 64'(want.entry_valid), 64'(m_axis_tdata[5]));
				check_field("entry_level", 64'(want.entry_level), 64'(m_axis_tdata[21:6]));
				check_field("entry_score", 64'(want.entry_score), 64'(m_axis_tdata[53:22]));
				check_field("count", 64'(want.count), 64'(m_axis_tdata[57:54]));
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_reads();
		test_fill_and_order();
		test_full_table();
		test_random_traffic(1750);
		// let any stray result items come out before the final check
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d expected result items never came", $time,
				pending_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#(WATCHDOG);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: top_k_ranked_table.f
hw/rtl/tkrt_pkg.sv
hw/rtl/tkrt_cell.sv
hw/rtl/top_k_ranked_table.sv
tb/sv/top_k_ranked_table_tb.sv
